/* sv/bsmt_pkg.sv */
package bsmt_pkg;

    // Command codes carried in the low two bits of an input beat.
    localparam logic [1:0] CMD_QUERY  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    // Control flags of the token that walks the cell chain.
    typedef struct packed {
        logic active;   // token present in this stage
        logic apply;    // 0: search pass, 1: apply pass
        logic hit;      // search: some earlier cell holds the value
        logic free;     // search: some earlier cell is unused
        logic claimed;  // apply: the insert has already taken a slot
        logic do_ins;   // apply: store the value in the first free slot
        logic do_rem;   // apply: clear the slot that holds the value
    } tok_flags_t;

endpackage

/* sv/bsmt_cell.sv */
module bsmt_cell
    import bsmt_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tok_flags_t             in_flags,
    input  logic [VALUE_WIDTH-1:0] in_value,
    output tok_flags_t             out_flags,
    output logic [VALUE_WIDTH-1:0] out_value
);

    logic [VALUE_WIDTH-1:0] slot_value_reg;
    logic                   slot_valid_reg;
    logic                   slot_valid_next;
    logic                   slot_load;
    tok_flags_t             flags_reg;
    tok_flags_t             flags_next;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic                   match;
    logic                   claim;

    assign match = slot_valid_reg && (slot_value_reg == in_value);
    assign claim = in_flags.active && in_flags.apply && in_flags.do_ins
                   && !in_flags.claimed && !slot_valid_reg;

    always_comb begin
        flags_next      = in_flags;
        slot_valid_next = slot_valid_reg;
        slot_load       = 1'b0;
        if (in_flags.active && !in_flags.apply) begin
            flags_next.hit  = in_flags.hit | match;
            flags_next.free = in_flags.free | !slot_valid_reg;
        end else if (in_flags.active && in_flags.apply) begin
            if (claim) begin
                slot_valid_next    = 1'b1;
                slot_load          = 1'b1;
                flags_next.claimed = 1'b1;
            end
            if (in_flags.do_rem && match) begin
                slot_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= 1'b0;
            flags_reg      <= '0;
        end else begin
            slot_valid_reg <= slot_valid_next;
            flags_reg      <= flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= in_value;
        if (slot_load) begin
            slot_value_reg <= in_value;
        end
    end

    assign out_flags = flags_reg;
    assign out_value = value_reg;

endmodule

/* sv/bounded_set_membership_table.sv */
// Bounded set membership table. The block holds up to DEPTH distinct values
// in a chain of DEPTH cells, each cell owning one slot (a value and an
// occupancy bit). Every input beat carries a command (query, insert, remove;
// the unused code acts as a query) and a value, and yields exactly one
// result beat with was_present, changed, full_error, the element count after
// the command (low five bits) and an empty flag. Only the low VALUE_WIDTH
// bits of the value take part. The block works on one command at a time: a
// token first walks the whole chain to learn whether the value is present
// and whether a free slot exists, then walks it again to store or clear the
// slot. The result beat is registered after the apply token leaves the last
// cell, and a new command is accepted only after that result is loaded, so
// no new command is taken before the last one is through. Inserts fill the
// lowest-numbered free slot. A result beat that waits for m_tready does not
// hold up acceptance of the next command; only a second finished result
// waits for the first to drain, and the input stalls while it does. No
// clearing pass is needed after reset.
module bounded_set_membership_table
    import bsmt_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Bits from the lowest up: command [1:0], value [33:2], zero fill [39:34].
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Bits from the lowest up: was_present [0], changed [1], full_error [2],
    // count [7:3], is_empty [8], zero fill [15:9].
    output logic [15:0] m_tdata
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Controller states.
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_APPLY  = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [1:0]             state_reg;
    logic [1:0]             state_next;
    logic [1:0]             cmd_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   hit_reg;
    logic                   changed_reg;
    logic                   full_reg;
    logic                   m_tvalid_reg;
    logic [15:0]            m_tdata_reg;

    logic                   s_accept;
    logic                   out_load;
    logic                   search_end;
    logic                   apply_end;
    logic                   do_ins;
    logic                   do_rem;
    logic                   full_now;

    logic [VALUE_WIDTH+31:0] value_ext;
    logic [VALUE_WIDTH-1:0]  in_value;
    logic [CNT_W+4:0]        count_ext;

    tok_flags_t             head_flags;
    logic [VALUE_WIDTH-1:0] head_value;
    tok_flags_t             chain_flags [DEPTH];
    logic [VALUE_WIDTH-1:0] chain_value [DEPTH];
    tok_flags_t             tail_flags;

    // The value field is 32 bits wide; the set works on its low VALUE_WIDTH
    // bits, zero-extended when VALUE_WIDTH is wider than the field.
    assign value_ext = {{VALUE_WIDTH{1'b0}}, s_tdata[33:2]};
    assign in_value  = value_ext[VALUE_WIDTH-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    assign tail_flags = chain_flags[DEPTH-1];
    assign search_end = (state_reg == ST_SEARCH) && tail_flags.active && !tail_flags.apply;
    assign apply_end  = (state_reg == ST_APPLY) && tail_flags.active && tail_flags.apply;

    // Decisions taken when the search token leaves the last cell.
    assign do_ins   = (cmd_reg == CMD_INSERT) && !tail_flags.hit && tail_flags.free;
    assign do_rem   = (cmd_reg == CMD_REMOVE) && tail_flags.hit;
    assign full_now = (cmd_reg == CMD_INSERT) && !tail_flags.hit && !tail_flags.free;

    // Token entering the first cell: a search token on acceptance, an apply
    // token when the search token comes out of the chain.
    always_comb begin
        head_flags = '0;
        head_value = value_reg;
        if (s_accept) begin
            head_flags.active = 1'b1;
            head_value        = in_value;
        end else if (search_end) begin
            head_flags.active = 1'b1;
            head_flags.apply  = 1'b1;
            head_flags.do_ins = do_ins;
            head_flags.do_rem = do_rem;
        end
    end

    generate
        for (genvar i = 0; i < DEPTH; i++) begin : g_cell
            if (i == 0) begin : g_head
                bsmt_cell #(
                    .VALUE_WIDTH(VALUE_WIDTH)
                ) u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .in_flags (head_flags),
                    .in_value (head_value),
                    .out_flags(chain_flags[i]),
                    .out_value(chain_value[i])
                );
            end else begin : g_body
                bsmt_cell #(
                    .VALUE_WIDTH(VALUE_WIDTH)
                ) u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .in_flags (chain_flags[i-1]),
                    .in_value (chain_value[i-1]),
                    .out_flags(chain_flags[i]),
                    .out_value(chain_value[i])
                );
            end
        end
    endgenerate

    // Element count follows the decision at the end of the search pass.
    always_comb begin
        count_next = count_reg;
        if (search_end && do_ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (search_end && do_rem && (count_reg != '0)) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (search_end) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (apply_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign count_ext = {5'd0, count_reg};

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg   <= s_tdata[1:0];
            value_reg <= in_value;
        end
        if (search_end) begin
            hit_reg     <= tail_flags.hit;
            changed_reg <= do_ins || do_rem;
            full_reg    <= full_now;
        end
        if (out_load) begin
            m_tdata_reg <= {7'd0, (count_reg == '0), count_ext[4:0],
                            full_reg, changed_reg, hit_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
